/* hdl/mwe_pkg.sv */
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared types and constants for the Microwire serial EEPROM block.
// ----------------------------------------------------------------------------
package mwe_pkg;

  localparam int ADDR_BITS_DEF   = 6;
  localparam int WORD_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;

  // Bus access modes as they arrive on the input channel.
  localparam logic [1:0] MODE_PIN    = 2'd0;
  localparam logic [1:0] MODE_CTRL   = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // Bit positions inside bits_in and the pin latch.
  localparam int PIN_DI_BIT      = 0;
  localparam int PIN_CLK_BIT     = 1;
  localparam int PIN_CS_BIT      = 2;
  localparam int PIN_DO_BIT      = 3;
  localparam int CTRL_ENABLE_BIT = 3;
  localparam int CTRL_RESET_BIT  = 7;

  // Opcode field and extended sub-opcodes of the serial command.
  localparam logic [1:0] OP_EXT   = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_ERASE = 2'b11;
  localparam logic [1:0] SUB_EWDS = 2'b00;
  localparam logic [1:0] SUB_ERAL = 2'b01;
  localparam logic [1:0] SUB_WRAL = 2'b10;
  localparam logic [1:0] SUB_EWEN = 2'b11;

  typedef enum logic [1:0] {
    KIND_PIN,
    KIND_CTRL,
    KIND_STATUS
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  bits;
  } item_t;

endpackage

/* hdl/mwe_ram.sv */
// ----------------------------------------------------------------------------
// mwe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mwe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mwe_front.sv */
// ----------------------------------------------------------------------------
// mwe_front
// Input stage: takes bus accesses and tags each one with its kind.
// ----------------------------------------------------------------------------
module mwe_front
  import mwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] bits_in,
  output logic       push,
  output item_t      push_item,
  input  logic       queue_full
);

  logic       held;
  item_t      item;
  item_kind_t kind_now;

  always_comb begin
    unique case (mode)
      MODE_PIN:    kind_now = KIND_PIN;
      MODE_CTRL:   kind_now = KIND_CTRL;
      MODE_STATUS: kind_now = KIND_STATUS;
      default:     kind_now = KIND_STATUS;
    endcase
  end

  assign push      = held && !queue_full;
  assign in_stall  = held && queue_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      item.kind <= kind_now;
      item.bits <= bits_in;
    end
  end

endmodule

/* hdl/mwe_queue.sv */
// ----------------------------------------------------------------------------
// mwe_queue
// Short FIFO that decouples the input stage from the sequencer.
// ----------------------------------------------------------------------------
module mwe_queue
  import mwe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (full && push) |-> pop)
    else $error("queue pushed while full");

endmodule

/* hdl/mwe_back.sv */
// ----------------------------------------------------------------------------
// mwe_back
// Microwire sequencer: runs each queued access against the word store and
// registers the status result.
// ----------------------------------------------------------------------------
module mwe_back
  import mwe_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  item_t      head_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] pin_readback,
  output logic       access_enabled
);

  localparam int CMD_BITS = ADDR_BITS + 2;
  localparam int DEPTH    = 1 << ADDR_BITS;
  localparam int CNT_MAX  = (WORD_BITS > CMD_BITS) ? WORD_BITS : CMD_BITS;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_CMD,
    PH_WRITE,
    PH_READ,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_LOAD,
    BK_SWEEP
  } back_state_t;

  back_state_t           bst, bst_next;
  phase_t                phase, phase_next;
  logic [3:0]            pin_latch, pin_latch_next;
  logic                  write_enable, write_enable_next;
  logic [CMD_BITS-1:0]   command_shift, command_shift_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic [WORD_BITS-1:0]  data_shift, data_shift_next;
  logic                  enable_flag, enable_flag_next;
  logic [DEPTH-1:0]      valid_bits, valid_bits_next;
  logic [ADDR_BITS-1:0]  sweep_addr, sweep_addr_next;
  logic                  out_valid_next;
  logic [2:0]            pin_readback_next;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;

  logic [2:0]            pins;
  logic                  di;
  logic                  rising;
  logic [CMD_BITS-1:0]   cmd_shifted;
  logic [1:0]            op;
  logic [1:0]            sub;
  logic [ADDR_BITS-1:0]  cmd_addr;
  logic [ADDR_BITS-1:0]  new_addr;
  logic [CNT_W-1:0]      cnt_inc;
  logic [WORD_BITS-1:0]  data_shifted;

  assign pop          = head_valid && (bst == BK_RUN) && (!out_valid || !out_stall);
  assign pins         = head_item.bits[2:0];
  assign di           = pins[PIN_DI_BIT];
  assign rising       = pins[PIN_CLK_BIT] && !pin_latch[PIN_CLK_BIT];
  assign cmd_shifted  = {command_shift[CMD_BITS-2:0], di};
  assign op           = cmd_shifted[ADDR_BITS+1:ADDR_BITS];
  assign sub          = cmd_shifted[ADDR_BITS-1:ADDR_BITS-2];
  assign cmd_addr     = command_shift[ADDR_BITS-1:0];
  assign new_addr     = cmd_shifted[ADDR_BITS-1:0];
  assign cnt_inc      = bit_count + 1'b1;
  assign data_shifted = {data_shift[WORD_BITS-2:0], di};

  // The RAM is read at the next command address, so in the cycle after a READ
  // decode its output holds the addressed word.
  mwe_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (command_shift_next[ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    bst_next           = bst;
    phase_next         = phase;
    pin_latch_next     = pin_latch;
    write_enable_next  = write_enable;
    command_shift_next = command_shift;
    bit_count_next     = bit_count;
    data_shift_next    = data_shift;
    enable_flag_next   = enable_flag;
    valid_bits_next    = valid_bits;
    sweep_addr_next    = sweep_addr;
    ram_we             = 1'b0;
    ram_waddr          = cmd_addr;
    ram_wdata          = data_shift;

    unique case (bst)
      BK_LOAD: begin
        // A word never written still holds its erased value.
        data_shift_next = valid_bits[cmd_addr] ? ram_rdata : '1;
        bst_next        = BK_RUN;
      end
      BK_SWEEP: begin
        ram_we          = 1'b1;
        ram_waddr       = sweep_addr;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == '1) begin
          valid_bits_next = '1;
          bst_next        = BK_RUN;
        end
      end
      BK_RUN: begin
      end
      default: begin
      end
    endcase

    if (pop) begin
      unique case (head_item.kind)
        KIND_PIN: begin
          if (!pins[PIN_CS_BIT]) begin
            if (pin_latch[PIN_CS_BIT]) begin
              phase_next = PH_START;
            end
            pin_latch_next = {1'b1, pins};
          end else begin
            pin_latch_next = {pin_latch[PIN_DO_BIT], pins};
            if (rising) begin
              unique case (phase)
                PH_START: begin
                  if (di) begin
                    phase_next         = PH_CMD;
                    command_shift_next = '0;
                    bit_count_next     = '0;
                  end
                end
                PH_CMD: begin
                  command_shift_next = cmd_shifted;
                  bit_count_next     = cnt_inc;
                  if (cnt_inc == CNT_W'(CMD_BITS)) begin
                    unique case (op)
                      OP_EXT: begin
                        unique case (sub)
                          SUB_EWEN: begin
                            write_enable_next = 1'b1;
                            phase_next        = PH_DONE;
                          end
                          SUB_EWDS: begin
                            write_enable_next = 1'b0;
                            phase_next        = PH_DONE;
                          end
                          SUB_ERAL: begin
                            pin_latch_next[PIN_DO_BIT] = 1'b1;
                            phase_next                 = PH_DONE;
                            if (write_enable) begin
                              valid_bits_next = '0;
                            end
                          end
                          SUB_WRAL: begin
                            phase_next      = PH_WRITE;
                            bit_count_next  = '0;
                            data_shift_next = '0;
                          end
                          default: begin
                          end
                        endcase
                      end
                      OP_WRITE: begin
                        phase_next      = PH_WRITE;
                        bit_count_next  = '0;
                        data_shift_next = '0;
                      end
                      OP_READ: begin
                        phase_next                 = PH_READ;
                        pin_latch_next[PIN_DO_BIT] = 1'b0;
                        bit_count_next             = '0;
                        bst_next                   = BK_LOAD;
                      end
                      OP_ERASE: begin
                        if (write_enable) begin
                          valid_bits_next[new_addr] = 1'b0;
                        end
                        phase_next                 = PH_DONE;
                        pin_latch_next[PIN_DO_BIT] = 1'b1;
                      end
                      default: begin
                      end
                    endcase
                  end
                end
                PH_WRITE: begin
                  data_shift_next = data_shifted;
                  bit_count_next  = cnt_inc;
                  if (cnt_inc == CNT_W'(WORD_BITS)) begin
                    if (write_enable) begin
                      if (command_shift[ADDR_BITS]) begin
                        ram_we                    = 1'b1;
                        ram_waddr                 = cmd_addr;
                        ram_wdata                 = data_shifted;
                        valid_bits_next[cmd_addr] = 1'b1;
                      end else begin
                        bst_next        = BK_SWEEP;
                        sweep_addr_next = '0;
                      end
                    end
                    pin_latch_next[PIN_DO_BIT] = 1'b1;
                    phase_next                 = PH_DONE;
                  end
                end
                PH_READ: begin
                  pin_latch_next[PIN_DO_BIT] = data_shift[WORD_BITS-1];
                  data_shift_next            = {data_shift[WORD_BITS-2:0], 1'b0};
                  bit_count_next             = cnt_inc;
                  if (cnt_inc == CNT_W'(WORD_BITS)) begin
                    phase_next = PH_DONE;
                  end
                end
                PH_DONE: begin
                end
                default: begin
                end
              endcase
            end
          end
        end
        KIND_CTRL: begin
          if (head_item.bits[CTRL_RESET_BIT]) begin
            write_enable_next  = 1'b0;
            phase_next         = PH_START;
            command_shift_next = '0;
            bit_count_next     = '0;
            pin_latch_next     = 4'b1000;
          end
          enable_flag_next = head_item.bits[CTRL_ENABLE_BIT];
        end
        KIND_STATUS: begin
        end
        default: begin
        end
      endcase
    end

    pin_readback_next = {pin_latch_next[PIN_CS_BIT], 1'b1, pin_latch_next[PIN_DO_BIT]};
    if (pop) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst           <= BK_RUN;
      phase         <= PH_START;
      pin_latch     <= 4'b1000;
      write_enable  <= 1'b0;
      command_shift <= '0;
      bit_count     <= '0;
      data_shift    <= '0;
      enable_flag   <= 1'b0;
      valid_bits    <= '0;
      sweep_addr    <= '0;
      out_valid     <= 1'b0;
    end else begin
      bst           <= bst_next;
      phase         <= phase_next;
      pin_latch     <= pin_latch_next;
      write_enable  <= write_enable_next;
      command_shift <= command_shift_next;
      bit_count     <= bit_count_next;
      data_shift    <= data_shift_next;
      enable_flag   <= enable_flag_next;
      valid_bits    <= valid_bits_next;
      sweep_addr    <= sweep_addr_next;
      out_valid     <= out_valid_next;
    end
    if (pop) begin
      pin_readback   <= pin_readback_next;
      access_enabled <= enable_flag_next;
    end
  end

  a_load_in_read: assert property (@(posedge clk) disable iff (rst)
    (bst == BK_LOAD) |-> (phase == PH_READ))
    else $error("word load outside a read command");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (bst == BK_LOAD) |=> (bst == BK_RUN))
    else $error("word load did not finish in one cycle");

  a_sweep_enabled: assert property (@(posedge clk) disable iff (rst)
    (bst == BK_SWEEP) |-> write_enable)
    else $error("write-all sweep running with writes disabled");

endmodule

/* hdl/microwire_serial_eeprom_top.sv */
// ----------------------------------------------------------------------------
// microwire_serial_eeprom_top
// 64x16 Microwire serial EEPROM seen through a CPU pin register.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ----------------------------------------
//   input    in_valid / in_stall  mode[1:0], bits_in[7:0]
//   output   out_valid/out_stall  pin_readback[2:0], access_enabled
//
// Every input transfer yields exactly one output transfer, in order.
// The sequencer retires one access per cycle while it is in its run state
// and the output is not stalled, so items flow at one per cycle; each passes
// the input register, the queue and the result register. The access that
// decodes a READ command is followed by a load state, in which no access is
// taken while the addressed word is fetched from the store RAM, and a WRAL
// that completes with writes enabled is followed by a sweep state that writes
// every word through the single RAM write port.
// Reset is synchronous and active high; it marks every word as erased
// through per-word valid bits, so no clearing pass is needed.
// A stall on the output holds the result register and backs up into the
// queue and then onto in_stall; in_stall never depends on in_valid.
module microwire_serial_eeprom_top
  import mwe_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] bits_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] pin_readback,
  output logic       access_enabled
);

  // Classified accesses travel from the input stage into the queue.
  logic  push;
  item_t push_item;
  logic  queue_full;

  // Head of the queue as seen by the sequencer.
  logic  head_valid;
  item_t head_item;
  logic  pop;

  // The input stage registers each transfer and tags it as a pin write,
  // a control write or a status read.
  mwe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .bits_in    (bits_in),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // The queue lets the input side keep taking transfers while the
  // sequencer is busy with a word fetch or a write-all sweep.
  mwe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // The sequencer owns all EEPROM state and the result register.
  mwe_back #(
    .ADDR_BITS (ADDR_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_readback   (pin_readback),
    .access_enabled (access_enabled)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Microwire serial EEPROM block behind its pin register.
// A scoreboard class mirrors the EEPROM sequencer, the word store and the
// enable flag. For every accepted bus access it computes the expected pin
// readback. Every result transfer is checked against it in order. The
// stimulus bit-bangs serial commands with random content, mixed with noise,
// control writes and status reads. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mwe_pkg::*;

  localparam int AW = ADDR_BITS_DEF;
  localparam int WW = WORD_BITS_DEF;
  localparam int CW = AW + 2;
  localparam int RANDOM_ACCESSES = 900;
  // The block leaves mode 3 unused. The mirror treats it like a status read.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Serial commands that the stimulus knows how to build.
  typedef enum int {
    CMD_READ, CMD_WRITE, CMD_ERASE, CMD_EWEN, CMD_EWDS, CMD_ERAL, CMD_WRAL
  } cmd_kind_t;

  // Where the serial sequencer stands between clock edges.
  typedef enum logic [2:0] {
    SEQ_WAIT_START, SEQ_COMMAND, SEQ_SHIFT_IN, SEQ_SHIFT_OUT, SEQ_DONE
  } seq_phase_t;

  typedef struct packed {
    logic [2:0] pin;
    logic       en;
  } readback_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the EEPROM and keeps the readbacks still to arrive.
  // --------------------------------------------------------------------------
  class readback_scoreboard;
    logic [WW-1:0] cells [1 << AW];
    logic [3:0]    latch;
    logic          wr_en;
    seq_phase_t    seq_phase;
    logic [CW-1:0] cmd_word;
    logic [4:0]    bit_cnt;
    logic [WW-1:0] shift_word;
    logic          en_flag;
    readback_t     expected_readback[$];
    int            errors;
    int            checked;

    function new();
      foreach (cells[i]) cells[i] = '1;
      shift_word = '0;
      errors = 0;
      checked = 0;
      clear_sequencer();
    endfunction

    function int pending();
      return expected_readback.size();
    endfunction

    // A control reset also clears the enable flag. The caller then sets the
    // flag again from the same control write.
    function void clear_sequencer();
      en_flag = 1'b0;
      latch = '0;
      latch[PIN_DO_BIT] = 1'b1;
      wr_en = 1'b0;
      seq_phase = SEQ_WAIT_START;
      cmd_word = '0;
      bit_cnt = '0;
    endfunction

    function void fill_cells(logic [WW-1:0] value);
      foreach (cells[i]) cells[i] = value;
    endfunction

    function void decode_command();
      logic [1:0]    op;
      logic [1:0]    sub;
      logic [AW-1:0] addr;
      op = cmd_word[CW-1 -: 2];
      sub = cmd_word[AW-1 -: 2];
      addr = cmd_word[AW-1:0];
      case (op)
        OP_EXT: begin
          case (sub)
            SUB_EWEN: begin
              wr_en = 1'b1;
              seq_phase = SEQ_DONE;
            end
            SUB_EWDS: begin
              wr_en = 1'b0;
              seq_phase = SEQ_DONE;
            end
            SUB_ERAL: begin
              latch[PIN_DO_BIT] = 1'b1;
              seq_phase = SEQ_DONE;
              if (wr_en) fill_cells('1);
            end
            SUB_WRAL: begin
              seq_phase = SEQ_SHIFT_IN;
              bit_cnt = '0;
              shift_word = '0;
            end
          endcase
        end
        OP_WRITE: begin
          seq_phase = SEQ_SHIFT_IN;
          bit_cnt = '0;
          shift_word = '0;
        end
        OP_READ: begin
          // The dummy zero comes out before the word.
          seq_phase = SEQ_SHIFT_OUT;
          latch[PIN_DO_BIT] = 1'b0;
          bit_cnt = '0;
        end
        OP_ERASE: begin
          if (wr_en) cells[addr] = '1;
          seq_phase = SEQ_DONE;
          latch[PIN_DO_BIT] = 1'b1;
        end
      endcase
    endfunction

    function void pin_write(logic [2:0] pins);
      logic rising;
      logic di;
      if (!pins[PIN_CS_BIT]) begin
        if (latch[PIN_CS_BIT]) seq_phase = SEQ_WAIT_START;
        latch = {1'b1, pins};
        return;
      end
      rising = pins[PIN_CLK_BIT] && !latch[PIN_CLK_BIT];
      latch = {latch[PIN_DO_BIT], pins};
      if (!rising) return;
      di = pins[PIN_DI_BIT];
      case (seq_phase)
        SEQ_WAIT_START: begin
          if (di) begin
            seq_phase = SEQ_COMMAND;
            cmd_word = '0;
            bit_cnt = '0;
          end
        end
        SEQ_COMMAND: begin
          cmd_word = {cmd_word[CW-2:0], di};
          bit_cnt++;
          if (bit_cnt == CW) decode_command();
        end
        SEQ_SHIFT_IN: begin
          shift_word = {shift_word[WW-2:0], di};
          bit_cnt++;
          if (bit_cnt < WW) return;
          // The low opcode bit tells WRITE from WRAL.
          if (wr_en) begin
            if (cmd_word[AW]) cells[cmd_word[AW-1:0]] = shift_word;
            else fill_cells(shift_word);
          end
          latch[PIN_DO_BIT] = 1'b1;
          seq_phase = SEQ_DONE;
        end
        SEQ_SHIFT_OUT: begin
          bit_cnt++;
          if (bit_cnt > WW) bit_cnt = 5'(WW);
          latch[PIN_DO_BIT] = cells[cmd_word[AW-1:0]][WW - bit_cnt];
          if (bit_cnt == WW) seq_phase = SEQ_DONE;
        end
        default: ;
      endcase
    endfunction

    function void note_access(logic [1:0] mode_v, logic [7:0] bits_v);
      readback_t rb;
      if (mode_v == MODE_PIN) begin
        pin_write(bits_v[2:0]);
      end else if (mode_v == MODE_CTRL) begin
        if (bits_v[CTRL_RESET_BIT]) clear_sequencer();
        en_flag = bits_v[CTRL_ENABLE_BIT];
      end
      rb.pin = {latch[PIN_CS_BIT], 1'b1, latch[PIN_DO_BIT]};
      rb.en = en_flag;
      expected_readback.push_back(rb);
    endfunction

    function void check_readback(logic [2:0] pin_v, logic en_v);
      readback_t rb;
      checked++;
      if (expected_readback.size() == 0) begin
        $error("result with no access waiting: pin_readback %0h access_enabled %0b",
               pin_v, en_v);
        errors++;
        return;
      end
      rb = expected_readback.pop_front();
      if (pin_v !== rb.pin) begin
        $error("pin_readback: expected %0h, actual %0h", rb.pin, pin_v);
        errors++;
      end
      if (en_v !== rb.en) begin
        $error("access_enabled: expected %0b, actual %0b", rb.en, en_v);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [7:0] bits_in;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] pin_readback;
  logic       access_enabled;

  readback_scoreboard board;
  bit quiet;            // no idling on either side while set
  int counted;          // pin and control transfers accepted so far
  int drains;
  int kind_count[7];

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  microwire_serial_eeprom_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .bits_in       (bits_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pin_readback  (pin_readback),
    .access_enabled(access_enabled)
  );

  // The receiver stalls now and then, but never during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 7);
  end

  // Results are taken at the rising edge. The values seen here are the ones
  // the block saw before the edge updated anything.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_readback(pin_readback, access_enabled);
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task starts and ends just after a falling edge. in_valid
  // stays high from one transfer to the next unless an idle cycle comes in.
  // --------------------------------------------------------------------------
  task automatic send(input logic [1:0] mode_v, input logic [7:0] bits_v);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= mode_v;
    bits_in <= bits_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_access(mode_v, bits_v);
    if (mode_v == MODE_PIN || mode_v == MODE_CTRL) counted++;
    @(negedge clk);
  endtask

  // A pin write. The unused upper bits carry noise.
  task automatic pin(input bit cs, input bit ck, input bit di);
    logic [7:0] b;
    b = 8'($urandom);
    b[PIN_CS_BIT] = cs;
    b[PIN_CLK_BIT] = ck;
    b[PIN_DI_BIT] = di;
    send(MODE_PIN, b);
  endtask

  // One serial bit: the clock goes low, then high, with the data held. Now
  // and then a status read or a control write falls between the two. A
  // repeated high write with flipped data is not an edge and must be ignored.
  task automatic clock_bit(input bit di);
    int r;
    pin(1'b1, 1'b0, di);
    r = $urandom_range(0, 99);
    if (r < 4) send(MODE_STATUS, 8'($urandom));
    else if (r == 4) send(MODE_CTRL, 8'(($urandom & 8'h7F) | 8'h08));
    pin(1'b1, 1'b1, di);
    if ($urandom_range(0, 99) < 4) pin(1'b1, 1'b1, !di);
  endtask

  // Selects the chip, clocks in a whole command and drops select again.
  // When cut is set, select drops somewhere in the middle of the command.
  task automatic run_command(input cmd_kind_t kind, input logic [AW-1:0] addr,
                             input logic [WW-1:0] word, input bit cut);
    logic [CW-1:0] cmd;
    bit            seq[$];
    int            len;
    case (kind)
      CMD_READ:  cmd = {OP_READ, addr};
      CMD_WRITE: cmd = {OP_WRITE, addr};
      CMD_ERASE: cmd = {OP_ERASE, addr};
      CMD_EWEN:  cmd = {OP_EXT, SUB_EWEN, addr[AW-3:0]};
      CMD_EWDS:  cmd = {OP_EXT, SUB_EWDS, addr[AW-3:0]};
      CMD_ERAL:  cmd = {OP_EXT, SUB_ERAL, addr[AW-3:0]};
      default:   cmd = {OP_EXT, SUB_WRAL, addr[AW-3:0]};
    endcase
    seq = {};
    // Zeros before the start bit are edges that the sequencer skips.
    repeat ($urandom_range(0, 2)) seq.push_back(1'b0);
    seq.push_back(1'b1);
    for (int i = CW - 1; i >= 0; i--) seq.push_back(cmd[i]);
    if (kind == CMD_WRITE || kind == CMD_WRAL) begin
      for (int i = WW - 1; i >= 0; i--) seq.push_back(word[i]);
    end else if (kind == CMD_READ) begin
      repeat (WW) seq.push_back(1'($urandom));
    end
    // Extra edges after the command has finished must change nothing.
    repeat ($urandom_range(0, 2)) seq.push_back(1'($urandom));
    len = cut ? $urandom_range(1, seq.size() - 1) : seq.size();
    pin(1'b1, 1'b0, 1'b0);
    for (int i = 0; i < len; i++) clock_bit(seq[i]);
    pin(1'b0, 1'($urandom), 1'($urandom));
    kind_count[kind]++;
  endtask

  // The sender holds off until every readback is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    drains++;
  endtask

  function automatic cmd_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_READ;
    if (r < 50) return CMD_WRITE;
    if (r < 60) return CMD_ERASE;
    if (r < 75) return CMD_EWEN;
    if (r < 83) return CMD_EWDS;
    if (r < 88) return CMD_ERAL;
    if (r < 95) return CMD_WRAL;
    return CMD_READ;
  endfunction

  // Half of the commands use the lowest eight words, so that reads often
  // find data that was written earlier.
  function automatic logic [AW-1:0] pick_addr();
    if ($urandom_range(0, 1) == 1) return AW'($urandom_range(0, 7));
    return AW'($urandom);
  endfunction

  function automatic logic [WW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return WW'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    cmd_kind_t     sweep[12];
    logic [AW-1:0] a;
    int            base;
    int            r;
    in_valid = 1'b0;
    mode = MODE_PIN;
    bits_in = '0;
    out_stall = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    counted = 0;
    drains = 0;
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: the mode and bit extremes, and the pin special cases.
    send(MODE_STATUS, 8'h00);
    send(MODE_UNUSED, 8'hFF);       // unused mode: status only
    send(MODE_CTRL, 8'hFF);         // sequencer reset together with enable set
    send(MODE_CTRL, 8'h00);         // enable cleared, no reset
    send(MODE_CTRL, 8'h08);
    send(MODE_PIN, 8'hFF);          // rising edge with data high is the start bit
    send(MODE_PIN, 8'h07);          // clock still high, so no edge
    send(MODE_PIN, 8'h04);
    send(MODE_PIN, 8'h06);          // first command bit, a zero
    send(MODE_PIN, 8'h00);          // select drops mid-command
    send(MODE_PIN, 8'h02);          // clock with select low
    send(MODE_PIN, 8'h06);          // select returns with the clock already high
    send(MODE_PIN, 8'h04);
    send(MODE_PIN, 8'h07);          // start bit again
    send(MODE_PIN, 8'h04);
    send(MODE_PIN, 8'h07);
    send(MODE_CTRL, 8'h80);         // sequencer reset in the middle of a command
    send(MODE_STATUS, 8'hFF);
    send(MODE_PIN, 8'h05);          // latch starts from a low clock after reset
    send(MODE_PIN, 8'hF8);          // select low with noise in the upper bits
    send(MODE_STATUS, 8'h55);
    drain();

    // Every command at least once, all on one address. The writes run first with
    // writes enabled and then with writes disabled.
    a = pick_addr();
    sweep = '{CMD_EWEN, CMD_WRITE, CMD_READ, CMD_ERASE, CMD_READ, CMD_WRAL,
              CMD_READ, CMD_ERAL, CMD_READ, CMD_EWDS, CMD_WRITE, CMD_READ};
    for (int i = 0; i < 12; i++) run_command(sweep[i], a, pick_word(), 1'b0);
    drain();

    // Random part. Mostly well-formed commands with random content. The
    // rest is cut commands, raw noise, control writes, drains and status reads.
    // One stretch in the middle runs with no idling on either side.
    base = counted;
    while (counted - base < RANDOM_ACCESSES) begin
      quiet = (counted - base >= 350) && (counted - base < 600);
      r = $urandom_range(0, 99);
      if (r < 82) begin
        run_command(pick_kind(), pick_addr(), pick_word(), $urandom_range(0, 9) == 0);
      end else if (r < 90) begin
        send(2'($urandom), 8'($urandom));
      end else if (r < 95) begin
        send(MODE_CTRL, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                    : 8'($urandom & 8'h7F));
      end else if (r < 97) begin
        drain();
      end else begin
        send(MODE_STATUS, 8'($urandom));
      end
    end
    quiet = 1'b0;

    // Wait for the last readbacks. Then allow a full WRAL sweep more, so
    // that a stray late result would still be caught.
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat ((1 << AW) + 16) @(posedge clk);

    $display("Covered %0d pin and control transfers, %0d readbacks checked, %0d drains.",
             counted, board.checked, drains);
    $display("Commands: read %0d, write %0d, erase %0d, ewen %0d, ewds %0d, eral %0d, wral %0d.",
             kind_count[CMD_READ], kind_count[CMD_WRITE], kind_count[CMD_ERASE],
             kind_count[CMD_EWEN], kind_count[CMD_EWDS], kind_count[CMD_ERAL],
             kind_count[CMD_WRAL]);
    if (board.pending() != 0) $error("%0d readbacks never arrived", board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // This limit is far beyond the length of a correct run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hdl/mwe_pkg.sv
hdl/mwe_ram.sv
hdl/mwe_front.sv
hdl/mwe_queue.sv
hdl/mwe_back.sv
hdl/microwire_serial_eeprom_top.sv
dv/tb_top.sv
